FILE: sv/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types and constants for the 24-bit bit stream packer.
// ----------------------------------------------------------------------------
`default_nettype none

package bsp_pkg;

    // word and field widths
    localparam int WORD_BITS = 24;
    localparam int ADDR_W    = 24;
    localparam int COUNT_W   = 5;
    localparam int CAP_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 24;

    // storage word capacity in each mode
    localparam logic [CAP_W-1:0] FULL_CAP = CAP_W'(WORD_BITS);
    localparam logic [CAP_W-1:0] HALF_CAP = CAP_W'(16);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIXTEEN_BIT_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS    = 1'b1;

    // input transaction payload
    typedef struct packed {
        logic [COUNT_W-1:0]   bit_count;
        logic [WORD_BITS-1:0] accumulator;
    } in_item_t;

    // result transaction payload
    typedef struct packed {
        logic [WORD_BITS-1:0] accumulator_out;
        logic                 write_valid;
        logic [ADDR_W-1:0]    write_address;
        logic [WORD_BITS-1:0] write_data;
        logic [COUNT_W-1:0]   fill_count;
    } out_item_t;

    // staging state carried between transactions
    typedef struct packed {
        logic [WORD_BITS-1:0] staged_word;
        logic [COUNT_W-1:0]   staged_bits;
        logic [ADDR_W-1:0]    write_pointer;
    } stage_state_t;

endpackage

`default_nettype wire

FILE: sv/bsp_pack_unit.sv
// ----------------------------------------------------------------------------
// bsp_pack_unit
// Combinational append step: shifts accumulator bits into the staged word,
// detects a full word and forms the storage write and the next state.
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_pack_unit
(
    input  wire bsp_pkg::in_item_t     item,
    input  wire bsp_pkg::stage_state_t state,
    input  wire logic                  sixteen_bit_mode,
    output bsp_pkg::out_item_t         result,
    output bsp_pkg::stage_state_t      state_next
);

    localparam int W = bsp_pkg::WORD_BITS;

    logic [bsp_pkg::COUNT_W-1:0] count;
    logic [bsp_pkg::CAP_W-1:0]   cap;
    logic [bsp_pkg::COUNT_W:0]   fill_sum;
    logic                        no_write;
    logic [bsp_pkg::COUNT_W-1:0] first;
    logic [bsp_pkg::COUNT_W-1:0] rest;
    logic [2*W-1:0]              pair;
    logic [2*W-1:0]              shifted_all;
    logic [2*W-1:0]              shifted_first;
    logic [2*W-1:0]              rest_mask_wide;
    logic [W-1:0]                rest_mask;

    always_comb
    begin
        // saturate oversized counts to the word width
        if (item.bit_count > bsp_pkg::COUNT_W'(W))
            count = bsp_pkg::COUNT_W'(W);
        else
            count = item.bit_count;

        cap      = sixteen_bit_mode ? bsp_pkg::HALF_CAP : bsp_pkg::FULL_CAP;
        fill_sum = {1'b0, state.staged_bits} + {1'b0, count};
        no_write = fill_sum < {1'b0, cap};

        // bits needed to complete the word; none when already overfull
        if (state.staged_bits < cap)
            first = cap - state.staged_bits;
        else
            first = '0;
        rest = count - first;

        // double-width shifts of {staged word, accumulator}
        pair           = {state.staged_word, item.accumulator};
        shifted_all    = pair << count;
        shifted_first  = pair << first;
        rest_mask_wide = {{W{1'b0}}, {W{1'b1}}} << rest;
        rest_mask      = rest_mask_wide[2*W-1:W];

        result.accumulator_out = shifted_all[W-1:0];

        if (no_write)
        begin
            result.write_valid       = 1'b0;
            result.write_address     = '0;
            result.write_data        = '0;
            state_next.staged_word   = shifted_all[2*W-1:W];
            state_next.staged_bits   = fill_sum[bsp_pkg::COUNT_W-1:0];
            state_next.write_pointer = state.write_pointer;
        end
        else
        begin
            // full word goes out, leftover bits start a fresh word
            result.write_valid       = 1'b1;
            result.write_address     = state.write_pointer;
            result.write_data        = shifted_first[2*W-1:W];
            state_next.staged_word   = shifted_all[2*W-1:W] & rest_mask;
            state_next.staged_bits   = rest;
            state_next.write_pointer = state.write_pointer + bsp_pkg::ADDR_W'(1);
        end

        result.fill_count = state_next.staged_bits;
    end

endmodule

`default_nettype wire

FILE: sv/bit_stream_packer_24.sv
// ----------------------------------------------------------------------------
// bit_stream_packer_24
// Write staging register for bit strings with 24-bit storage words.
// ----------------------------------------------------------------------------
// Each input transaction appends the top bit_count bits of the accumulator
// to a staged word and returns one result: the shifted accumulator, the new
// fill and, when the word filled up (24 bits, or 16 in sixteen-bit mode), a
// storage write of the staged word at the write pointer, which then steps
// by one and wraps at 24 bits. The block takes one transaction per clock
// while the output is not stalled. An accepted transaction is held in the
// input register while the append logic works on it, and its result is
// then registered in the result register, where it waits to be taken. While
// the result waits, the input register holds the next transaction and the
// input stalls. The staging state is updated as each transaction moves into
// the result register, so back-to-back transactions see each other's state.
// Writing start_address also loads the write pointer; configure only while
// idle.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_stream_packer_24
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire bsp_pkg::in_item_t                  in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output bsp_pkg::out_item_t                      out_data,
    input  wire logic                               cfg_we,
    input  wire logic [bsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bsp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic                  in_valid_reg;
    bsp_pkg::in_item_t     in_item_reg;
    logic                  out_valid_reg;
    bsp_pkg::out_item_t    out_item_reg;
    bsp_pkg::stage_state_t state_reg;
    logic                  mode_reg;

    bsp_pkg::out_item_t    result;
    bsp_pkg::stage_state_t state_next;
    logic                  advance;

    // pipeline flow control
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // append step
    bsp_pack_unit u_pack
    (
        .item             (in_item_reg),
        .state            (state_reg),
        .sixteen_bit_mode (mode_reg),
        .result           (result),
        .state_next       (state_next)
    );

    // control and staging state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            mode_reg      <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (advance)
                state_reg <= state_next;

            // configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    bsp_pkg::REG_SIXTEEN_BIT_MODE:
                        mode_reg <= cfg_data[0];
                    bsp_pkg::REG_START_ADDRESS:
                        state_reg.write_pointer <= cfg_data[bsp_pkg::ADDR_W-1:0];
                    default:
                        ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_item_reg <= in_data;
        if (advance)
            out_item_reg <= result;
    end

endmodule

`default_nettype wire

FILE: tb/tb_bit_stream_packer_24.sv
// ----------------------------------------------------------------------------
// tb_bit_stream_packer_24
// Self-checking testbench for the 24-bit bit stream packer.
// ----------------------------------------------------------------------------
// Every accepted request is run through a local model of the staging
// register, which yields the expected result: the shifted accumulator, the
// new fill and any storage write. Results are compared field by field in
// order. A short directed table covers the field extremes, pointer wrap,
// saturating counts and overfull fills after a mode switch. Random phases
// under several configurations follow, with random idling on both sides, a
// long output stall and a phase at full rate.
// ----------------------------------------------------------------------------

module tb_bit_stream_packer_24;

    import bsp_pkg::*;

    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 100;

    typedef enum logic {ROW_ITEM, ROW_CONFIG} row_kind_t;

    // one line of the directed table
    typedef struct packed {
        row_kind_t            kind;
        logic [COUNT_W-1:0]   bit_count;
        logic [WORD_BITS-1:0] accumulator;
        logic                 typed;
        out_item_t            want;
        logic                 sixteen;
        logic [ADDR_W-1:0]    start;
    } row_t;

    localparam out_item_t         NO_WANT = '0;
    localparam logic [ADDR_W:0]   NO_CFG  = '0;
    localparam int                N_ROWS  = 22;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    // model state and configuration
    logic [WORD_BITS-1:0] st_word   = '0;
    logic [COUNT_W-1:0]   st_bits   = '0;
    logic [ADDR_W-1:0]    st_ptr    = '0;
    logic                 cfg_sixteen = 1'b0;

    out_item_t expected_results [$];
    int        mismatches   = 0;
    int        quiet_cycles = 0;
    int        gap_pct      = 27;
    bit        stall_out_req = 1'b0;

    // directed table, starting from the reset state
    row_t directed_rows [0:N_ROWS-1] = '{
        {ROW_ITEM,   5'd0,  24'h000000, 1'b1, {24'h0, 1'b0, 24'h0, 24'h000000, 5'd0}, NO_CFG},
        {ROW_ITEM,   5'd24, 24'hFFFFFF, 1'b1, {24'h0, 1'b1, 24'h0, 24'hFFFFFF, 5'd0}, NO_CFG},
        {ROW_ITEM,   5'd31, 24'hABCDEF, 1'b1, {24'h0, 1'b1, 24'h1, 24'hABCDEF, 5'd0}, NO_CFG},
        {ROW_ITEM,   5'd1,  24'h800000, 1'b0, NO_WANT, NO_CFG},
        {ROW_ITEM,   5'd23, 24'h7FFFFE, 1'b0, NO_WANT, NO_CFG},
        {ROW_ITEM,   5'd12, 24'h123456, 1'b0, NO_WANT, NO_CFG},
        {ROW_ITEM,   5'd11, 24'hFFFFFF, 1'b0, NO_WANT, NO_CFG},
        {ROW_ITEM,   5'd1,  24'h800000, 1'b0, NO_WANT, NO_CFG},
        {ROW_ITEM,   5'd20, 24'hC3C3C3, 1'b0, NO_WANT, NO_CFG},
        {ROW_CONFIG, 5'd0,  24'h000000, 1'b0, NO_WANT, 1'b1, 24'hFFFFFE},
        {ROW_ITEM,   5'd4,  24'hF00000, 1'b0, NO_WANT, NO_CFG},
        {ROW_ITEM,   5'd12, 24'hABCDEF, 1'b0, NO_WANT, NO_CFG},
        {ROW_ITEM,   5'd16, 24'hFFFF00, 1'b0, NO_WANT, NO_CFG},
        {ROW_ITEM,   5'd24, 24'h5A5A5A, 1'b0, NO_WANT, NO_CFG},
        {ROW_ITEM,   5'd7,  24'hFE0000, 1'b0, NO_WANT, NO_CFG},
        {ROW_ITEM,   5'd24, 24'hFFFFFF, 1'b0, NO_WANT, NO_CFG},
        {ROW_ITEM,   5'd0,  24'h000000, 1'b0, NO_WANT, NO_CFG},
        {ROW_ITEM,   5'd30, 24'h123456, 1'b0, NO_WANT, NO_CFG},
        {ROW_ITEM,   5'd17, 24'h000001, 1'b0, NO_WANT, NO_CFG},
        {ROW_CONFIG, 5'd0,  24'h000000, 1'b0, NO_WANT, 1'b0, 24'h000000},
        {ROW_ITEM,   5'd16, 24'hFFFFFF, 1'b0, NO_WANT, NO_CFG},
        {ROW_ITEM,   5'd25, 24'h000000, 1'b0, NO_WANT, NO_CFG}
    };

    bit_stream_packer_24 dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // append one request to the staged word and return the expected result
    function automatic out_item_t predict_append(input in_item_t req);
        int          take;
        int          lead;
        int          cap;
        int          fill;
        logic [47:0] pair;
        out_item_t   res;
        res  = '0;
        take = (req.bit_count > WORD_BITS) ? WORD_BITS : int'(req.bit_count);
        cap  = cfg_sixteen ? int'(HALF_CAP) : int'(FULL_CAP);
        fill = int'(st_bits);
        pair = {st_word, req.accumulator};
        if (fill + take < cap)
        begin
            pair = pair << take;
            fill = fill + take;
        end
        else
        begin
            // top up to capacity (nothing when already overfull), then flush
            lead = (fill < cap) ? cap - fill : 0;
            pair = pair << lead;
            res.write_valid   = 1'b1;
            res.write_address = st_ptr;
            res.write_data    = pair[47:24];
            st_ptr = st_ptr + 1'b1;
            pair = {24'h0, pair[23:0]} << (take - lead);
            fill = take - lead;
        end
        st_word = pair[47:24];
        st_bits = fill[COUNT_W-1:0];
        res.accumulator_out = pair[23:0];
        res.fill_count      = st_bits;
        return res;
    endfunction

    function automatic in_item_t random_request();
        in_item_t req;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 8)
            req.bit_count = COUNT_W'($urandom_range(31, 25));
        else if (pick < 12)
            req.bit_count = '0;
        else if (pick < 18)
            req.bit_count = COUNT_W'(WORD_BITS);
        else
            req.bit_count = COUNT_W'($urandom_range(23, 1));
        pick = $urandom_range(99);
        if (pick < 5)
            req.accumulator = '0;
        else if (pick < 10)
            req.accumulator = '1;
        else
            req.accumulator = WORD_BITS'($urandom);
        return req;
    endfunction

    function automatic void report_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // offer one transaction, called at a rising edge; returns at acceptance
    task automatic send_request(input in_item_t req, input logic typed, input out_item_t want);
        out_item_t predicted;
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_append(req);
        expected_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // write both registers; the address write also reloads the pointer
    task automatic load_config(input logic sixteen, input logic [ADDR_W-1:0] start);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SIXTEEN_BIT_MODE;
        cfg_data  <= CFG_DATA_W'(sixteen);
        @(posedge clk);
        cfg_index <= REG_START_ADDRESS;
        cfg_data  <= start;
        @(posedge clk);
        cfg_we      <= 1'b0;
        cfg_sixteen = sixteen;
        st_ptr      = start;
    endtask

    // receiver: random backpressure, with a long hold when requested
    initial
    begin : receiver
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_out_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                stall_out_req = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= gap_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
            end
            else
            begin
                want = expected_results.pop_front();
                report_field("accumulator_out", want.accumulator_out, out_data.accumulator_out);
                report_field("write_valid", want.write_valid, out_data.write_valid);
                report_field("write_address", want.write_address, out_data.write_address);
                report_field("write_data", want.write_data, out_data.write_data);
                report_field("fill_count", want.fill_count, out_data.fill_count);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin : stimulus
        logic              sixteen;
        logic [ADDR_W-1:0] start;
        in_item_t          req;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CONFIG)
            begin
                wait_for_results();
                load_config(directed_rows[r].sixteen, directed_rows[r].start);
            end
            else
            begin
                req.bit_count   = directed_rows[r].bit_count;
                req.accumulator = directed_rows[r].accumulator;
                send_request(req, directed_rows[r].typed, directed_rows[r].want);
            end
        end

        // random phases under different settings, third one at full rate
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_for_results();
            case (phase)
                0:       begin sixteen = 1'b0; start = 24'hFFFFFF; end
                1:       begin sixteen = 1'b1; start = 24'h000000; end
                2:       begin sixteen = 1'b0; start = ADDR_W'($urandom); end
                default: begin sixteen = 1'b1; start = ADDR_W'($urandom); end
            endcase
            load_config(sixteen, start);
            gap_pct = (phase == 2) ? 0 : 27;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // long output hold while requests keep coming
                if (phase == 0 && i == 30)
                    stall_out_req = 1'b1;
                // sender pause until the pipeline is empty
                if (phase == 1 && i == 50)
                    wait_for_results();
                send_request(random_request(), 1'b0, NO_WANT);
            end
        end

        wait_for_results();
        repeat (6) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: bit_stream_packer_24.f
sv/bsp_pkg.sv
sv/bsp_pack_unit.sv
sv/bit_stream_packer_24.sv
tb/tb_bit_stream_packer_24.sv
